/* sv/lic_pkg.sv */
// ----------------------------------------------------------------------------
// lic_pkg
// Shared types and constants for the list insert/search/delete unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lic_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int POS_W         = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_MATCH,
    CELL_CLOSE,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REPORT,
    S_CLOSE,
    S_DUMP
  } state_t;

  // summary of the cell row seen by the controller
  typedef struct packed {
    logic                     found;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] head;
  } chain_stat_t;

endpackage

`default_nettype wire

/* sv/list_insert_search_delete_unit.sv */
// ----------------------------------------------------------------------------
// list_insert_search_delete_unit
// Bounded newest-first list of signed 32-bit values in a row of shift cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries opcode and value; output
// channel (out_valid / out_stall) carries status, position, entry_value
// and last. A transaction moves when valid is high and stall is low.
// Insert pushes at the head in the accept cycle unless full and reports once
// the output register is free. Delete compares every cell in the accept
// cycle, then removes the first match and closes the gap while reporting.
// Dump rotates the cell row one place per cycle while the output is free
// and emits the head each time, one result per cycle and per entry; the
// rotation leaves the list as it was. One item is worked on at a time; the
// next one is taken once the last result of the current one sits in the
// output register, which the receiver may keep stalled. Mid-item, a stalled
// receiver freezes the sequencer and the cells in place. Reset empties the
// list and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module list_insert_search_delete_unit #(
  parameter int DEPTH = lic_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        opcode,
  input  wire logic signed [lic_pkg::DATA_W-1:0] value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             status,
  output logic [lic_pkg::POS_W-1:0]              position,
  output logic signed [lic_pkg::DATA_W-1:0]      entry_value,
  output logic                                   last
);

  lic_pkg::cell_op_t    cmd;
  lic_pkg::chain_stat_t stat;

  logic signed [lic_pkg::DATA_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]                  cell_occ;
  logic [DEPTH-1:0]                  cell_first;
  logic [DEPTH:0]                    cell_found;

  assign cell_found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [lic_pkg::DATA_W-1:0] lv, rv;
    logic                              lo, ro;
    if (i == 0) begin : g_head
      assign lv = value;
      assign lo = 1'b1;
    end else begin : g_mid
      assign lv = cell_value[i-1];
      assign lo = cell_occ[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_body
      assign rv = cell_value[i+1];
      assign ro = cell_occ[i+1];
    end
    lic_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .key         (value),
      .left_value  (lv),
      .left_occ    (lo),
      .right_value (rv),
      .right_occ   (ro),
      .head_value  (cell_value[0]),
      .found_in    (cell_found[i]),
      .value       (cell_value[i]),
      .occ         (cell_occ[i]),
      .first       (cell_first[i]),
      .found_out   (cell_found[i+1])
    );
  end

  // one-hot first match selects position and value
  always_comb begin
    stat.found = cell_found[DEPTH];
    stat.pos   = '0;
    stat.value = '0;
    stat.head  = cell_value[0];
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_first[i]) begin
        stat.pos   = stat.pos | lic_pkg::POS_W'(i + 1);
        stat.value = stat.value | cell_value[i];
      end
    end
  end

  lic_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .stat        (stat),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .position    (position),
    .entry_value (entry_value),
    .last        (last)
  );

endmodule

`default_nettype wire

/* sv/lic_cell.sv */
// ----------------------------------------------------------------------------
// lic_cell
// One list slot: holds a value and an occupied bit, shifts toward either
// neighbor, and registers its own match against the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire lic_pkg::cell_op_t                cmd,
  input  wire logic signed [lic_pkg::DATA_W-1:0] key,
  input  wire logic signed [lic_pkg::DATA_W-1:0] left_value,
  input  wire logic                             left_occ,
  input  wire logic signed [lic_pkg::DATA_W-1:0] right_value,
  input  wire logic                             right_occ,
  input  wire logic signed [lic_pkg::DATA_W-1:0] head_value,
  input  wire logic                             found_in,
  output logic signed [lic_pkg::DATA_W-1:0]      value,
  output logic                                  occ,
  output logic                                  first,
  output logic                                  found_out
);

  logic match;

  assign found_out = found_in | match;
  assign first     = match & ~found_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= 1'b0;
      match <= 1'b0;
    end else begin
      case (cmd)
        lic_pkg::CELL_PUSH: begin
          occ <= left_occ;
        end
        lic_pkg::CELL_MATCH: begin
          match <= occ && (value == key);
        end
        lic_pkg::CELL_CLOSE: begin
          if (found_out) begin
            occ <= right_occ;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      lic_pkg::CELL_PUSH: begin
        value <= left_value;
      end
      lic_pkg::CELL_CLOSE: begin
        // cells from the first match on take their right neighbor
        if (found_out) begin
          value <= right_value;
        end
      end
      lic_pkg::CELL_ROTATE: begin
        // tail cell wraps the head around
        if (occ) begin
          value <= right_occ ? right_value : head_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/lic_ctrl.sv */
// ----------------------------------------------------------------------------
// lic_ctrl
// Sequencer for the list unit: decodes transactions, drives the cell row,
// tracks the entry count and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_ctrl #(
  parameter int DEPTH = lic_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        opcode,
  input  wire lic_pkg::chain_stat_t              stat,
  output lic_pkg::cell_op_t                      cmd,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             status,
  output logic [lic_pkg::POS_W-1:0]              position,
  output logic signed [lic_pkg::DATA_W-1:0]      entry_value,
  output logic                                   last
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  lic_pkg::state_t  state, state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  lic_pkg::status_t rpt_status;

  logic in_accept;
  logic out_free;
  logic full;
  logic dump_last;

  logic                             load;
  lic_pkg::status_t                 status_d;
  logic [lic_pkg::POS_W-1:0]        pos_d;
  logic signed [lic_pkg::DATA_W-1:0] value_d;
  logic                             last_d;

  assign in_stall  = (state != lic_pkg::S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;
  assign full      = (count == CNT_W'(DEPTH));
  assign dump_last = (idx == count - CNT_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      lic_pkg::S_IDLE: begin
        if (in_accept) begin
          case (lic_pkg::op_t'(opcode))
            lic_pkg::OP_INSERT: state_next = lic_pkg::S_REPORT;
            lic_pkg::OP_DELETE: state_next = lic_pkg::S_CLOSE;
            lic_pkg::OP_DUMP: begin
              state_next = (count == '0) ? lic_pkg::S_REPORT : lic_pkg::S_DUMP;
            end
            default: state_next = lic_pkg::S_IDLE;
          endcase
        end
      end
      lic_pkg::S_REPORT: begin
        if (out_free) state_next = lic_pkg::S_IDLE;
      end
      lic_pkg::S_CLOSE: begin
        if (out_free) state_next = lic_pkg::S_IDLE;
      end
      lic_pkg::S_DUMP: begin
        if (out_free && dump_last) state_next = lic_pkg::S_IDLE;
      end
      default: state_next = lic_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = lic_pkg::CELL_HOLD;
    load     = 1'b0;
    status_d = lic_pkg::ST_OK;
    pos_d    = '0;
    value_d  = '0;
    last_d   = 1'b1;
    case (state)
      lic_pkg::S_IDLE: begin
        if (in_accept) begin
          case (lic_pkg::op_t'(opcode))
            lic_pkg::OP_INSERT: cmd = full ? lic_pkg::CELL_HOLD : lic_pkg::CELL_PUSH;
            lic_pkg::OP_DELETE: cmd = lic_pkg::CELL_MATCH;
            default:            cmd = lic_pkg::CELL_HOLD;
          endcase
        end
      end
      lic_pkg::S_REPORT: begin
        load     = out_free;
        status_d = rpt_status;
      end
      lic_pkg::S_CLOSE: begin
        load = out_free;
        if (out_free) cmd = lic_pkg::CELL_CLOSE;
        if (stat.found) begin
          pos_d   = stat.pos;
          value_d = stat.value;
        end else begin
          status_d = lic_pkg::ST_NOTFOUND;
        end
      end
      lic_pkg::S_DUMP: begin
        load = out_free;
        if (out_free) cmd = lic_pkg::CELL_ROTATE;
        pos_d   = lic_pkg::POS_W'(idx + CNT_W'(1));
        value_d = stat.head;
        last_d  = dump_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lic_pkg::S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == lic_pkg::CELL_PUSH) begin
        count <= count + CNT_W'(1);
      end else if (cmd == lic_pkg::CELL_CLOSE && stat.found) begin
        count <= count - CNT_W'(1);
      end
      if (in_accept) begin
        idx <= '0;
      end else if (cmd == lic_pkg::CELL_ROTATE) begin
        idx <= idx + CNT_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rpt_status <= (lic_pkg::op_t'(opcode) == lic_pkg::OP_INSERT)
                    ? (full ? lic_pkg::ST_FULL : lic_pkg::ST_OK)
                    : lic_pkg::ST_EMPTY;
    end
    if (load) begin
      status      <= status_d;
      position    <= pos_d;
      entry_value <= value_d;
      last        <= last_d;
    end
  end

endmodule

`default_nettype wire

/* sv/lic_checker.sv */
// ----------------------------------------------------------------------------
// lic_checker
// Port-level checks for the list unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic [1:0]                        opcode,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [1:0]                        status,
  input wire logic [lic_pkg::POS_W-1:0]         position,
  input wire logic signed [lic_pkg::DATA_W-1:0] entry_value
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  // a failed operation is a single result with no payload
  a_fail_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != lic_pkg::ST_OK) |-> (position == '0 && entry_value == '0))
    else $error("non-ok status carries position or value");

  // a meaningful opcode keeps the unit busy in the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (opcode == lic_pkg::OP_INSERT ||
     opcode == lic_pkg::OP_DELETE || opcode == lic_pkg::OP_DUMP)) |=> in_stall)
    else $error("transaction taken without sequencing");

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result withdrawn");

endmodule

bind list_insert_search_delete_unit lic_checker u_lic_checker (.*);

`default_nettype wire

/* tb/list_insert_search_delete_unit_test.sv */
// ----------------------------------------------------------------------------
// list_insert_search_delete_unit_test
// Self-checking bench for the newest-first list unit: a queue-fed driver
// sends insert, delete, dump and unused-opcode transactions with random
// gaps. A monitor predicts every result from its own copy of the list and
// checks each accepted result in order while the receiver stalls at random.
// ----------------------------------------------------------------------------

module list_insert_search_delete_unit_test;

  localparam int ENTRY_CAP    = lic_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 290;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 2 * ENTRY_CAP + 20;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [lic_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [lic_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [1:0]                        opcode;
    logic signed [lic_pkg::DATA_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    lic_pkg::status_t                  status;
    logic [lic_pkg::POS_W-1:0]         position;
    logic signed [lic_pkg::DATA_W-1:0] entry_value;
    logic                              last;
  } list_resp_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [1:0]                        opcode = '0;
  logic signed [lic_pkg::DATA_W-1:0] value = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [1:0]                        status;
  logic [lic_pkg::POS_W-1:0]         position;
  logic signed [lic_pkg::DATA_W-1:0] entry_value;
  logic                              last;

  list_req_t  req_queue[$];
  list_resp_t expected_resp[$];

  // model of the list, cell 0 is the head
  logic signed [lic_pkg::DATA_W-1:0] list_cells[ENTRY_CAP];
  int                                list_len = 0;

  logic signed [lic_pkg::DATA_W-1:0] value_pool[8];
  logic signed [lic_pkg::DATA_W-1:0] recent_values[$];

  int error_count = 0;
  int cycle_count = 0;
  int send_gap    = 0;
  int send_calm   = 0;
  int stall_left  = 0;
  int stall_calm  = 0;

  list_insert_search_delete_unit #(
    .DEPTH(ENTRY_CAP)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .position   (position),
    .entry_value(entry_value),
    .last       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic void predict_list_op(input list_req_t req);
    list_resp_t r;
    int         hit;
    r = '{status: lic_pkg::ST_OK, position: '0, entry_value: '0, last: 1'b1};
    hit = -1;
    case (req.opcode)
      lic_pkg::OP_INSERT: begin
        if (list_len >= ENTRY_CAP) begin
          r.status = lic_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) list_cells[i] = list_cells[i-1];
          list_cells[0] = req.value;
          list_len++;
        end
        expected_resp.push_back(r);
      end
      lic_pkg::OP_DELETE: begin
        for (int i = 0; i < list_len; i++) begin
          if (hit < 0 && list_cells[i] == req.value) hit = i;
        end
        if (hit < 0) begin
          r.status = lic_pkg::ST_NOTFOUND;
        end else begin
          r.position    = lic_pkg::POS_W'(hit + 1);
          r.entry_value = list_cells[hit];
          for (int i = hit; i < list_len - 1; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
        expected_resp.push_back(r);
      end
      lic_pkg::OP_DUMP: begin
        if (list_len == 0) begin
          r.status = lic_pkg::ST_EMPTY;
          expected_resp.push_back(r);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            r.position    = lic_pkg::POS_W'(i + 1);
            r.entry_value = list_cells[i];
            r.last        = (i == list_len - 1);
            expected_resp.push_back(r);
          end
        end
      end
      default: begin
        // unused opcode: no result, list untouched
      end
    endcase
  endfunction

  task automatic add_req(input logic [1:0] op,
                         input logic signed [lic_pkg::DATA_W-1:0] v);
    req_queue.push_back('{opcode: op, value: v});
    if (op == lic_pkg::OP_INSERT) begin
      recent_values.push_back(v);
      if (recent_values.size() > ENTRY_CAP) void'(recent_values.pop_front());
    end
  endtask

  // deletes mostly aim at values that were inserted lately so they hit
  function automatic logic signed [lic_pkg::DATA_W-1:0] pick_search_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65 && recent_values.size() != 0)
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    if (r < 85) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic signed [lic_pkg::DATA_W-1:0] pick_insert_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return value_pool[$urandom_range(0, 7)];
    if (r < 55 && recent_values.size() != 0)
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    return $urandom;
  endfunction

  task automatic build_stimulus();
    int         issued;
    int         kind;
    int         span;
    int         r;
    logic [1:0] op;
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = '0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    value_pool[5] = 32'sh5555_5555;
    value_pool[6] = 32'shaaaa_aaaa;
    value_pool[7] = $urandom;

    // directed: empty list, extremes, duplicates, head/tail/middle removal
    add_req(lic_pkg::OP_DUMP, $urandom);
    add_req(lic_pkg::OP_DELETE, 5);
    add_req(OP_UNUSED, $urandom);
    add_req(lic_pkg::OP_INSERT, VAL_MIN);
    add_req(lic_pkg::OP_INSERT, VAL_MAX);
    add_req(lic_pkg::OP_INSERT, 0);
    add_req(lic_pkg::OP_INSERT, -1);
    add_req(lic_pkg::OP_INSERT, VAL_MAX);
    add_req(lic_pkg::OP_DUMP, $urandom);
    add_req(lic_pkg::OP_DELETE, VAL_MAX);
    add_req(lic_pkg::OP_DELETE, VAL_MIN);
    add_req(lic_pkg::OP_DELETE, 12345);
    add_req(lic_pkg::OP_DUMP, $urandom);
    add_req(lic_pkg::OP_DELETE, 0);
    add_req(OP_UNUSED, $urandom);
    add_req(lic_pkg::OP_DELETE, -1);
    add_req(lic_pkg::OP_DELETE, VAL_MAX);
    add_req(lic_pkg::OP_DUMP, $urandom);

    // random phases: fill, drain or mixed; the first one fills past full
    issued = 0;
    kind   = 0;
    span   = 30;
    while (issued < RANDOM_ITEMS) begin
      for (int k = 0; k < span && issued < RANDOM_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          add_req(OP_UNUSED, $urandom);
        end else begin
          r = $urandom_range(0, 99);
          case (kind)
            0: begin
              op = (r < 85) ? lic_pkg::OP_INSERT :
                   (r < 93) ? lic_pkg::OP_DUMP : lic_pkg::OP_DELETE;
            end
            1: begin
              op = (r < 70) ? lic_pkg::OP_DELETE :
                   (r < 85) ? lic_pkg::OP_DUMP : lic_pkg::OP_INSERT;
            end
            default: begin
              op = (r < 40) ? lic_pkg::OP_INSERT :
                   (r < 75) ? lic_pkg::OP_DELETE : lic_pkg::OP_DUMP;
            end
          endcase
          case (op)
            lic_pkg::OP_INSERT: add_req(op, pick_insert_value());
            lic_pkg::OP_DELETE: add_req(op, pick_search_value());
            default:            add_req(op, $urandom);
          endcase
          issued++;
        end
      end
      kind = $urandom_range(0, 2);
      span = $urandom_range(12, 30);
    end
  endtask

  // sender
  always @(posedge clk) begin
    list_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (req_queue.size() != 0) begin
        req = req_queue.pop_front();
        in_valid <= 1'b1;
        opcode   <= req.opcode;
        value    <= req.value;
        if (send_calm > 0) begin
          send_gap  <= 0;
          send_calm <= send_calm - 1;
        end else begin
          send_gap <= pick_idle();
          if ($urandom_range(0, 19) == 0) send_calm <= $urandom_range(10, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    int stall_draw;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_calm > 0) begin
      out_stall  <= 1'b0;
      stall_calm <= stall_calm - 1;
    end else begin
      stall_draw = pick_idle();
      out_stall  <= (stall_draw > 0);
      stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
      if ($urandom_range(0, 24) == 0) stall_calm <= $urandom_range(10, 60);
    end
  end

  // check results first, then predict from the transaction taken at this edge
  always @(posedge clk) begin
    list_resp_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_resp.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_r = expected_resp.pop_front();
          if (status !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, exp_r.status));
          if (position !== exp_r.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      position, exp_r.position));
          if (entry_value !== exp_r.entry_value)
            report_mismatch($sformatf("entry_value %0d, expected %0d",
                                      entry_value, exp_r.entry_value));
          if (last !== exp_r.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, exp_r.last));
        end
      end
      if (in_valid && !in_stall) predict_list_op('{opcode: opcode, value: value});
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (req_queue.size() != 0 || in_valid) @(negedge clk);
    while (expected_resp.size() != 0) @(negedge clk);
    // any stray result arriving now still gets flagged
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
